### rtl/cts_pkg.sv
// Shared types and constants for the cooperative thread scheduler.
// No dependencies; imported by every module of the block.
`default_nettype none

package cts_pkg;

  // Size of the thread table
  localparam int THREADS = 16;
  localparam int TW      = $clog2(THREADS);

  // Field widths of the stream words
  localparam int OP_W      = 2;
  localparam int TGT_W     = 5;
  localparam int VAL_W     = 64;
  localparam int STATUS_W  = 3;
  localparam int THREAD_W  = 4;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 80;

  typedef enum logic [1:0] {
    SLOT_DEAD,
    SLOT_RUNNABLE,
    SLOT_RUNNING
  } slot_t;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE,
    OP_YIELD,
    OP_EXIT,
    OP_JOIN
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_NOFREE,
    ST_INVALID,
    ST_END,
    ST_WAIT
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } fsm_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the incoming word
    logic commit;  // update the thread table and the result register
  } cts_cmd_t;

endpackage

`default_nettype wire

### rtl/cts_ctrl.sv
// Controller of the thread scheduler: input handshake, sequencing, output valid.
// Depends on cts_pkg.
`default_nettype none

module cts_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output cts_pkg::cts_cmd_t     cmd
);
  import cts_pkg::*;

  fsm_t state;
  fsm_t state_next;
  logic out_free;

  // Result register can take a new word
  assign out_free = !m_tvalid || m_tready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    s_tready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      S_EXEC: begin
        cmd.commit = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid: set on commit, dropped once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### rtl/cts_datapath.sv
// Datapath of the thread scheduler: thread table, slot searches, result register.
// Depends on cts_pkg; driven by cts_ctrl commands.
`default_nettype none

module cts_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cts_pkg::cts_cmd_t           cmd,
  input  wire logic [cts_pkg::OP_W-1:0]    in_op,
  input  wire logic [cts_pkg::TGT_W-1:0]   in_tgt,
  input  wire logic [cts_pkg::VAL_W-1:0]   in_val,
  output logic [cts_pkg::STATUS_W-1:0]     status,
  output logic [cts_pkg::THREAD_W-1:0]     created_thread,
  output logic [cts_pkg::THREAD_W-1:0]     running_thread,
  output logic                             switched,
  output logic [cts_pkg::VAL_W-1:0]        joined_value
);
  import cts_pkg::*;

  // Thread table
  slot_t              slot_state [THREADS];
  logic               jn_valid   [THREADS];
  logic [TW-1:0]      jn_entry   [THREADS];
  logic               rv_valid   [THREADS];
  logic [VAL_W-1:0]   rv_data    [THREADS];
  logic [TW-1:0]      cur;

  // Captured word
  op_t                op_q;
  logic [TGT_W-1:0]   tgt_q;
  logic [VAL_W-1:0]   val_q;

  // Search results
  logic               yield_found;
  logic [TW-1:0]      yield_idx;
  logic               create_found;
  logic [TW-1:0]      create_idx;
  logic               exit_found;
  logic [TW-1:0]      exit_next;
  logic               low_found;
  logic [TW-1:0]      low_idx;
  logic [TW-1:0]      je;
  logic               joiner_ok;
  logic               slot0_ok;
  logic               tgt_bad;
  logic [TW-1:0]      tgt_idx;
  logic               join_wait;

  status_t            res_status;
  logic [TW-1:0]      res_created;
  logic [TW-1:0]      res_running;
  logic               res_sw;
  logic [VAL_W-1:0]   res_joined;

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= op_t'(in_op);
      tgt_q <= in_tgt;
      val_q <= in_val;
    end
  end

  // Round-robin search for the next runnable slot after the current one
  always_comb begin
    logic [TW:0] sum;
    yield_found = 1'b0;
    yield_idx   = cur;
    for (int k = 1; k < THREADS; k++) begin
      sum = {1'b0, cur} + (TW+1)'(k);
      if (sum >= (TW+1)'(THREADS)) sum = sum - (TW+1)'(THREADS);
      if (!yield_found && slot_state[sum[TW-1:0]] == SLOT_RUNNABLE) begin
        yield_found = 1'b1;
        yield_idx   = sum[TW-1:0];
      end
    end
  end

  // Lowest dead slot and lowest runnable slot other than the current one, from 1 up
  always_comb begin
    create_found = 1'b0;
    create_idx   = '0;
    low_found    = 1'b0;
    low_idx      = '0;
    for (int i = 1; i < THREADS; i++) begin
      if (!create_found && slot_state[i] == SLOT_DEAD) begin
        create_found = 1'b1;
        create_idx   = TW'(i);
      end
      if (!low_found && slot_state[i] == SLOT_RUNNABLE && TW'(i) != cur) begin
        low_found = 1'b1;
        low_idx   = TW'(i);
      end
    end
  end

  // Exit successor: runnable joiner, else slot 0, else lowest runnable
  assign je        = jn_entry[cur];
  assign joiner_ok = jn_valid[cur] && (je != cur) && (slot_state[je] == SLOT_RUNNABLE);
  assign slot0_ok  = (cur != '0) && (slot_state[0] != SLOT_DEAD);

  always_comb begin
    exit_found = 1'b1;
    exit_next  = '0;
    if (joiner_ok) begin
      exit_next = je;
    end else if (slot0_ok) begin
      exit_next = '0;
    end else if (low_found) begin
      exit_next = low_idx;
    end else begin
      exit_found = 1'b0;
    end
  end

  // Join target checks
  assign tgt_bad   = (tgt_q == '0) || (tgt_q >= TGT_W'(THREADS));
  assign tgt_idx   = tgt_q[TW-1:0];
  assign join_wait = !tgt_bad && (slot_state[tgt_idx] != SLOT_DEAD);

  // Result of the current operation
  always_comb begin
    res_status  = ST_OK;
    res_created = '0;
    res_running = cur;
    res_sw      = 1'b0;
    res_joined  = '0;
    case (op_q)
      OP_CREATE: begin
        if (create_found) res_created = create_idx;
        else              res_status  = ST_NOFREE;
      end
      OP_YIELD: begin
        res_running = yield_idx;
        res_sw      = yield_found;
      end
      OP_EXIT: begin
        if (exit_found) begin
          res_running = exit_next;
          res_sw      = 1'b1;
        end else begin
          res_status  = ST_END;
        end
      end
      OP_JOIN: begin
        if (tgt_bad) begin
          res_status = ST_INVALID;
        end else if (join_wait) begin
          res_status  = ST_WAIT;
          res_running = yield_idx;
          res_sw      = yield_found;
        end else if (rv_valid[tgt_idx]) begin
          res_joined = rv_data[tgt_idx];
        end
      end
      default: ;
    endcase
  end

  // Slot states, valid bits and current thread
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < THREADS; i++) begin
        slot_state[i] <= SLOT_DEAD;
        jn_valid[i]   <= 1'b0;
        rv_valid[i]   <= 1'b0;
      end
      slot_state[0] <= SLOT_RUNNING;
      cur           <= '0;
    end else if (cmd.commit) begin
      case (op_q)
        OP_CREATE: begin
          if (create_found) begin
            slot_state[create_idx] <= SLOT_RUNNABLE;
            jn_valid[create_idx]   <= 1'b0;
            rv_valid[create_idx]   <= 1'b0;
          end
        end
        OP_YIELD: begin
          if (yield_found) begin
            slot_state[cur]       <= SLOT_RUNNABLE;
            slot_state[yield_idx] <= SLOT_RUNNING;
            cur                   <= yield_idx;
          end
        end
        OP_EXIT: begin
          if (exit_found) begin
            slot_state[cur]       <= SLOT_DEAD;
            rv_valid[cur]         <= 1'b1;
            slot_state[exit_next] <= SLOT_RUNNING;
            cur                   <= exit_next;
          end else begin
            // no successor: back to a fresh process
            for (int i = 0; i < THREADS; i++) begin
              slot_state[i] <= SLOT_DEAD;
              jn_valid[i]   <= 1'b0;
              rv_valid[i]   <= 1'b0;
            end
            slot_state[0] <= SLOT_RUNNING;
            cur           <= '0;
          end
        end
        OP_JOIN: begin
          if (join_wait) begin
            jn_valid[tgt_idx] <= 1'b1;
            if (yield_found) begin
              slot_state[cur]       <= SLOT_RUNNABLE;
              slot_state[yield_idx] <= SLOT_RUNNING;
              cur                   <= yield_idx;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Joiner slots and return values; meaning held by the valid bits
  always_ff @(posedge clk) begin
    if (cmd.commit && op_q == OP_JOIN && join_wait) begin
      jn_entry[tgt_idx] <= cur;
    end
    if (cmd.commit && op_q == OP_EXIT && exit_found) begin
      rv_data[cur] <= val_q;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status         <= res_status;
      created_thread <= THREAD_W'(res_created);
      running_thread <= THREAD_W'(res_running);
      switched       <= res_sw;
      joined_value   <= res_joined;
    end
  end

endmodule

`default_nettype wire

### rtl/cooperative_thread_scheduler.sv
// Top level of the cooperative thread scheduler: stream ports, controller, datapath.
// Depends on cts_pkg, cts_ctrl and cts_datapath.
//
// Each word on the input stream is one scheduler operation (create, yield, exit,
// join) and produces exactly one result word. An operation first captures the word;
// then the slot searches over the 16-entry thread table (round-robin, lowest dead,
// lowest runnable) are evaluated and the table and the result register are updated.
// The result register decouples the output: a new word is accepted while the
// previous result is still waiting, and the block stalls in the update cycle only
// while that register is still full. No clearing pass is needed after reset; the
// table is valid from the first cycle out of reset.
`default_nettype none

module cooperative_thread_scheduler (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [cts_pkg::IN_DATA_W-1:0]     s_tdata,  // target_thread[4:0], exit_value[68:5]
  input  wire logic [cts_pkg::OP_W-1:0]          s_tuser,  // operation[1:0]
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [cts_pkg::OUT_DATA_W-1:0]         m_tdata   // status[2:0], created_thread[6:3],
                                                           // running_thread[10:7], switched[11],
                                                           // joined_value[75:12]
);
  import cts_pkg::*;

  cts_cmd_t               cmd;
  logic [STATUS_W-1:0]    status;
  logic [THREAD_W-1:0]    created_thread;
  logic [THREAD_W-1:0]    running_thread;
  logic                   switched;
  logic [VAL_W-1:0]       joined_value;

  cts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  cts_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .in_op          (s_tuser),
    .in_tgt         (s_tdata[TGT_W-1:0]),
    .in_val         (s_tdata[TGT_W+VAL_W-1:TGT_W]),
    .status         (status),
    .created_thread (created_thread),
    .running_thread (running_thread),
    .switched       (switched),
    .joined_value   (joined_value)
  );

  // Pack the result word, low field first
  assign m_tdata = {{(OUT_DATA_W-VAL_W-1-2*THREAD_W-STATUS_W){1'b0}},
                    joined_value, switched, running_thread, created_thread, status};

endmodule

`default_nettype wire

### rtl/cts_checker.sv
// Port-level checks for the cooperative thread scheduler, bound to the top level.
// Depends on cts_pkg for the status codes; sees only the top-level ports.
`default_nettype none

module cts_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [71:0] s_tdata,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [79:0] m_tdata
);
  import cts_pkg::*;

  // A stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // One operation in flight: no accept right after an accept
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an operation is in progress");

  // A switch is reported only with ok or join-waiting status
  a_sw: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[11] |-> m_tdata[2:0] == ST_OK || m_tdata[2:0] == ST_WAIT)
    else $error("switch reported with a failing status");

  // A created slot is reported only on success
  a_create: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[6:3] != 4'd0 |-> m_tdata[2:0] == ST_OK)
    else $error("created slot reported with a failing status");

  // Join value only comes with ok status and no switch
  a_join: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[75:12] != 64'd0 |-> m_tdata[2:0] == ST_OK && !m_tdata[11])
    else $error("joined value reported outside a completed join");

endmodule

bind cooperative_thread_scheduler cts_checker u_cts_checker (.*);

`default_nettype wire

### tb/cooperative_thread_scheduler_tb.sv
// Self-checking testbench for the cooperative thread scheduler.
// Needs only cts_pkg and cooperative_thread_scheduler; a built-in thread table
// model predicts every result word, which is checked against the output stream.
`timescale 1ns / 100ps

module cooperative_thread_scheduler_tb;
  import cts_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct {
    op_t              op;
    logic [TGT_W-1:0] tgt;
    logic [VAL_W-1:0] val;
  } sched_op_t;

  typedef struct {
    status_t             status;
    logic [THREAD_W-1:0] created;
    logic [THREAD_W-1:0] running;
    logic                sw;
    logic [VAL_W-1:0]    joined;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [OP_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // Model of the thread table
  slot_t         slot_st [THREADS];
  logic          joiner_ok [THREADS];
  logic [TW-1:0] joiner_id [THREADS];
  logic [VAL_W-1:0] ret_val [THREADS];
  logic [TW-1:0] cur_thread;

  sched_op_t     pending_ops[$];
  sched_result_t expected_results[$];
  int total_items = 0;
  int sent_count = 0;
  int idle_cycles = 0;
  int errors = 0;

  always #2 clk = ~clk;

  cooperative_thread_scheduler dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  function automatic void table_clear();
    for (int i = 0; i < THREADS; i++) begin
      slot_st[i]   = SLOT_DEAD;
      joiner_ok[i] = 1'b0;
      joiner_id[i] = '0;
      ret_val[i]   = '0;
    end
    slot_st[0] = SLOT_RUNNING;
    cur_thread = '0;
  endfunction

  // Round-robin hand-over; returns 1 when the running thread changed
  function automatic logic hand_over();
    logic [TW-1:0] prev;
    logic [TW-1:0] idx;
    logic found;
    prev = cur_thread;
    found = 1'b0;
    slot_st[prev] = SLOT_RUNNABLE;
    for (int k = 1; k <= THREADS; k++) begin
      idx = prev + TW'(k);
      if (!found && slot_st[idx] == SLOT_RUNNABLE) begin
        found = 1'b1;
        cur_thread = idx;
        slot_st[idx] = SLOT_RUNNING;
      end
    end
    if (!found) slot_st[prev] = SLOT_RUNNING;
    return found && (cur_thread != prev);
  endfunction

  // Apply one operation to the table and return the word it produces
  function automatic sched_result_t sched_apply(sched_op_t w);
    sched_result_t r;
    logic [TW-1:0] prev;
    logic [TW-1:0] nxt;
    logic have;
    r = '{ST_OK, '0, '0, 1'b0, '0};
    prev = cur_thread;
    have = 1'b0;
    nxt = '0;
    case (w.op)
      OP_CREATE: begin
        for (int i = 1; i < THREADS; i++) begin
          if (!have && slot_st[i] == SLOT_DEAD) begin
            have = 1'b1;
            nxt = TW'(i);
          end
        end
        if (!have) begin
          r.status = ST_NOFREE;
        end else begin
          slot_st[nxt]   = SLOT_RUNNABLE;
          joiner_ok[nxt] = 1'b0;
          joiner_id[nxt] = '0;
          ret_val[nxt]   = '0;
          r.created      = nxt;
        end
        r.running = cur_thread;
      end
      OP_YIELD: begin
        r.sw = hand_over();
        r.running = cur_thread;
      end
      OP_EXIT: begin
        ret_val[prev] = w.val;
        slot_st[prev] = SLOT_DEAD;
        // main first, else lowest other runnable slot
        if (slot_st[0] != SLOT_DEAD) begin
          have = 1'b1;
        end else begin
          for (int i = 1; i < THREADS; i++) begin
            if (!have && TW'(i) != prev && slot_st[i] == SLOT_RUNNABLE) begin
              have = 1'b1;
              nxt = TW'(i);
            end
          end
        end
        // a runnable joiner wins
        if (joiner_ok[prev] && slot_st[joiner_id[prev]] == SLOT_RUNNABLE) begin
          have = 1'b1;
          nxt = joiner_id[prev];
        end
        if (!have) begin
          r.status = ST_END;
          r.running = prev;
          table_clear();
        end else begin
          cur_thread = nxt;
          slot_st[nxt] = SLOT_RUNNING;
          r.sw = (nxt != prev);
          r.running = nxt;
        end
      end
      OP_JOIN: begin
        if (w.tgt == '0 || w.tgt >= THREADS) begin
          r.status = ST_INVALID;
        end else if (slot_st[w.tgt[TW-1:0]] == SLOT_DEAD) begin
          r.joined = ret_val[w.tgt[TW-1:0]];
        end else begin
          joiner_ok[w.tgt[TW-1:0]] = 1'b1;
          joiner_id[w.tgt[TW-1:0]] = prev;
          r.sw = hand_over();
          r.status = ST_WAIT;
        end
        r.running = cur_thread;
      end
    endcase
    return r;
  endfunction

  function automatic void add_op(op_t op, logic [TGT_W-1:0] tgt, logic [VAL_W-1:0] val);
    sched_op_t w;
    w.op = op;
    w.tgt = tgt;
    w.val = val;
    pending_ops.push_back(w);
  endfunction

  function automatic int load_phase();
    return (total_items == 0) ? 0 : (sent_count * 3) / total_items;
  endfunction

  // Driver: next operation word once the current one is taken
  always @(posedge clk) begin : drive_ops
    sched_op_t w;
    int gap_pct;
    gap_pct = (load_phase() == 0) ? 24 : (load_phase() == 1) ? 51 : 0;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= gap_pct) begin
        w = pending_ops.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= IN_DATA_W'({w.val, w.tgt});
        s_tuser <= w.op;
        sent_count <= sent_count + 1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Predict the result of each accepted word
  always @(posedge clk) begin : predict_results
    sched_op_t w;
    if (!rst && s_tvalid && s_tready) begin
      w.op = op_t'(s_tuser);
      w.tgt = s_tdata[TGT_W-1:0];
      w.val = s_tdata[TGT_W +: VAL_W];
      expected_results.push_back(sched_apply(w));
    end
  end

  // Monitor: compare each result word with the oldest prediction
  always @(posedge clk) begin : check_results
    sched_result_t e;
    int stall_pct;
    stall_pct = (load_phase() == 0) ? 51 : (load_phase() == 1) ? 24 : 0;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word %h", m_tdata);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (m_tdata[2:0] != e.status) begin
            $error("status: expected %0d, got %0d", e.status, m_tdata[2:0]);
            errors++;
          end
          if (m_tdata[6:3] != e.created) begin
            $error("created_thread: expected %0d, got %0d", e.created, m_tdata[6:3]);
            errors++;
          end
          if (m_tdata[10:7] != e.running) begin
            $error("running_thread: expected %0d, got %0d", e.running, m_tdata[10:7]);
            errors++;
          end
          if (m_tdata[11] != e.sw) begin
            $error("switched: expected %0d, got %0d", e.sw, m_tdata[11]);
            errors++;
          end
          if (m_tdata[75:12] != e.joined) begin
            $error("joined_value: expected %h, got %h", e.joined, m_tdata[75:12]);
            errors++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int r;
    int wc;
    int wy;
    int we;
    logic [TGT_W-1:0] tgt;
    logic [VAL_W-1:0] v;

    table_clear();

    // Directed: invalid and never-created targets, lone yield, process end
    add_op(OP_JOIN, 5'd0, '0);
    add_op(OP_JOIN, 5'd31, '0);
    add_op(OP_JOIN, 5'd16, '1);
    add_op(OP_JOIN, 5'd15, '0);
    add_op(OP_YIELD, 5'd0, '0);
    add_op(OP_EXIT, 5'd0, '1);
    // joiner overrides main on exit
    add_op(OP_CREATE, 5'd0, '0);
    add_op(OP_CREATE, 5'd0, '0);
    add_op(OP_JOIN, 5'd2, '0);
    add_op(OP_JOIN, 5'd2, '0);
    add_op(OP_EXIT, 5'd0, 64'h0123_4567_89ab_cdef);
    add_op(OP_JOIN, 5'd2, '0);
    // self join, then exit with a dead joiner
    add_op(OP_JOIN, 5'd1, '0);
    add_op(OP_YIELD, 5'd0, '0);
    add_op(OP_EXIT, 5'd0, 64'h8000_0000_0000_0001);
    // main exits while another thread is runnable
    add_op(OP_CREATE, 5'd0, '0);
    add_op(OP_YIELD, 5'd0, '0);
    add_op(OP_YIELD, 5'd0, '0);
    add_op(OP_EXIT, 5'd0, '0);
    add_op(OP_EXIT, 5'd0, 64'hfedc_ba98_7654_3210);

    // Random: segments that fill the table, churn, or drain it
    while (pending_ops.size() < 1150) begin
      case ($urandom_range(2))
        0: begin wc = 55; wy = 20; we = 5; end
        1: begin wc = 30; wy = 30; we = 15; end
        default: begin wc = 10; wy = 25; we = 40; end
      endcase
      for (int n = 0; n < 40; n++) begin
        r = $urandom_range(99);
        tgt = ($urandom_range(99) < 85) ? TGT_W'($urandom_range(15, 1))
                                        : TGT_W'($urandom_range(31));
        case ($urandom_range(9))
          0: v = '0;
          1: v = '1;
          default: v = {$urandom, $urandom};
        endcase
        if (r < wc) begin
          add_op(OP_CREATE, tgt, v);
        end else if (r < wc + wy) begin
          add_op(OP_YIELD, tgt, v);
        end else if (r < wc + wy + we) begin
          add_op(OP_EXIT, tgt, v);
        end else begin
          add_op(OP_JOIN, tgt, v);
          // software retry of a join
          if ($urandom_range(99) < 40) begin
            add_op(OP_YIELD, tgt, v);
            add_op(OP_JOIN, tgt, v);
          end
        end
      end
    end
    total_items = pending_ops.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while ((pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0) &&
           idle_cycles < STALL_LIMIT)
      @(negedge clk);

    if (idle_cycles >= STALL_LIMIT) begin
      $display("cooperative_thread_scheduler: mismatch");
    end else begin
      repeat (8) @(negedge clk);
      if (errors == 0) $display("cooperative_thread_scheduler: match");
      else $display("cooperative_thread_scheduler: mismatch");
    end
    $finish;
  end

endmodule

### cooperative_thread_scheduler.f
rtl/cts_pkg.sv
rtl/cts_ctrl.sv
rtl/cts_datapath.sv
rtl/cooperative_thread_scheduler.sv
rtl/cts_checker.sv
tb/cooperative_thread_scheduler_tb.sv
